/* rtl/core/framed_packet_receiver_crc32_core_defines.svh */
// ---------------------------------------------------------------------------
// Framed packet receiver assertion macros
// Shared concurrent assertion forms for the receiver core.
// ---------------------------------------------------------------------------
`ifndef FRAMED_PACKET_RECEIVER_CRC32_CORE_DEFINES_SVH
`define FRAMED_PACKET_RECEIVER_CRC32_CORE_DEFINES_SVH

// Checked on every rising edge outside reset.
`define FPR_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define FPR_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/core/fpr_pkg.sv */
// ---------------------------------------------------------------------------
// Framed packet receiver package
// Operation codes, queue entry type and the byte-wide CRC-32 update.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package fpr_pkg;

   localparam logic [31:0] CRC_PRESET  = 32'hFFFF_FFFF;
   localparam logic [31:0] CRC_POLY    = 32'h04C1_1DB7;
   localparam logic [7:0]  START_RESET = 8'hAA;

   typedef enum logic [2:0] {
      OP_FIRST    = 3'd0,
      OP_FEED     = 3'd1,
      OP_PAYLOAD  = 3'd2,
      OP_CRC_BYTE = 3'd3,
      OP_CRC_LAST = 3'd4
   } fpr_op_type;

   typedef struct packed {
      fpr_op_type  op;
      logic [7:0]  data;
      logic [7:0]  index;
      logic [7:0]  command;
      logic [7:0]  length;
   } fpr_entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } fpr_queue_status_type;

   function automatic logic [31:0] crc_feed(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] c;
      c = crc ^ {b, 24'h00_0000};
      for (int k = 0; k < 8; k++) begin
         c = c[31] ? ((c << 1) ^ CRC_POLY) : (c << 1);
      end
      return c;
   endfunction

endpackage

`default_nettype wire

/* rtl/core/framed_packet_receiver_crc32_core.sv */
// ---------------------------------------------------------------------------
// Framed packet receiver core with CRC-32 check
// Finds frames in a byte stream, reports payload bytes and the CRC verdict.
//
//   Channel  Direction  Handshake             Contents
//   req_     in         req_valid/req_stall   one received byte
//   rsp_     out        rsp_valid/rsp_stall   payload byte or end-of-frame result
//   csr_     in         csr_valid/csr_ready   start byte
//
// One request per cycle is taken while req_stall is low; its result, if any,
// passes through the queue and then through the result register.
// The back end folds each queued frame byte into the byte-wide CRC-32 update.
// Reset is synchronous and clears the frame state, queue count and result valid.
// A stalled result holds further results back while the queue absorbs up to
// QUEUE_DEPTH requests; req_stall rises when the queue is full.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "framed_packet_receiver_crc32_core_defines.svh"

module framed_packet_receiver_crc32_core #(
   parameter int QUEUE_DEPTH = 4
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   input  wire logic [7:0] req_rx_byte,
   output logic            req_stall,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic            rsp_kind,
   output logic [7:0]      rsp_payload_byte,
   output logic [7:0]      rsp_byte_index,
   output logic [7:0]      rsp_frame_command,
   output logic [7:0]      rsp_frame_length,
   output logic            rsp_crc_ok,
   input  wire logic       csr_valid,
   output logic            csr_ready,
   input  wire logic [7:0] csr_start_byte
);

   fpr_pkg::fpr_entry_type        push_entry;
   fpr_pkg::fpr_entry_type        head;
   fpr_pkg::fpr_queue_status_type q_status;
   logic                          push;
   logic                          pop;

   assign csr_ready = 1'b1;

   fpr_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_rx_byte    (req_rx_byte),
      .req_stall      (req_stall),
      .csr_valid      (csr_valid),
      .csr_start_byte (csr_start_byte),
      .q_status       (q_status),
      .push           (push),
      .push_entry     (push_entry)
   );

   fpr_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .status     (q_status)
   );

   fpr_back u_back (
      .clock             (clock),
      .reset             (reset),
      .head              (head),
      .q_status          (q_status),
      .pop               (pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_kind          (rsp_kind),
      .rsp_payload_byte  (rsp_payload_byte),
      .rsp_byte_index    (rsp_byte_index),
      .rsp_frame_command (rsp_frame_command),
      .rsp_frame_length  (rsp_frame_length),
      .rsp_crc_ok        (rsp_crc_ok)
   );

   `FPR_ASSERT(a_end_fields_clear, clock, reset,
      (rsp_valid && rsp_kind) |-> (rsp_payload_byte == 8'd0 && rsp_byte_index == 8'd0),
      "End-of-frame result carries payload data.")
   `FPR_ASSERT(a_payload_no_crc_ok, clock, reset, (rsp_valid && !rsp_kind) |-> !rsp_crc_ok,
      "Payload result carries a CRC verdict.")
   `FPR_ASSERT_ALWAYS(a_ready_after_reset, clock, reset |=> (!req_stall && !rsp_valid),
      "Core not empty after reset.")

endmodule

`default_nettype wire

/* rtl/core/fpr_front.sv */
// ---------------------------------------------------------------------------
// Framed packet receiver front end
// Tracks the frame structure, classifies each request and queues the work.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fpr_front (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   input  wire logic [7:0]             req_rx_byte,
   output logic                        req_stall,
   input  wire logic                   csr_valid,
   input  wire logic [7:0]             csr_start_byte,
   input  wire fpr_pkg::fpr_queue_status_type q_status,
   output logic                        push,
   output fpr_pkg::fpr_entry_type      push_entry
);

   typedef enum logic [2:0] {
      PH_IDLE = 3'd0,
      PH_CMD  = 3'd1,
      PH_LEN  = 3'd2,
      PH_PAY  = 3'd3,
      PH_CRC  = 3'd4
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [7:0]  start_ff, start_in;
   logic [7:0]  command_ff, command_in;
   logic [7:0]  length_ff, length_in;
   logic [7:0]  count_ff, count_in;
   logic [1:0]  crc_cnt_ff, crc_cnt_in;
   logic        take;

   assign req_stall = q_status.full;
   assign take      = req_valid && !q_status.full;

   always_comb begin
      phase_in   = phase_ff;
      start_in   = csr_valid ? csr_start_byte : start_ff;
      command_in = command_ff;
      length_in  = length_ff;
      count_in   = count_ff;
      crc_cnt_in = crc_cnt_ff;
      push       = 1'b0;
      push_entry.op      = fpr_pkg::OP_FEED;
      push_entry.data    = req_rx_byte;
      push_entry.index   = count_ff;
      push_entry.command = command_ff;
      push_entry.length  = length_ff;
      if (take) begin
         unique case (phase_ff)
            PH_CMD: begin
               command_in    = req_rx_byte;
               push          = 1'b1;
               push_entry.op = fpr_pkg::OP_FIRST;
               phase_in      = PH_LEN;
            end
            PH_LEN: begin
               length_in     = req_rx_byte;
               count_in      = 8'd0;
               crc_cnt_in    = 2'd0;
               push          = 1'b1;
               push_entry.op = fpr_pkg::OP_FEED;
               phase_in      = (req_rx_byte == 8'd0) ? PH_CRC : PH_PAY;
            end
            PH_PAY: begin
               push          = 1'b1;
               push_entry.op = fpr_pkg::OP_PAYLOAD;
               count_in      = count_ff + 8'd1;
               if ((count_ff + 8'd1) == length_ff) begin
                  phase_in = PH_CRC;
               end
            end
            PH_CRC: begin
               push = 1'b1;
               if (crc_cnt_ff == 2'd3) begin
                  push_entry.op = fpr_pkg::OP_CRC_LAST;
                  crc_cnt_in    = 2'd0;
                  phase_in      = PH_IDLE;
               end else begin
                  push_entry.op = fpr_pkg::OP_CRC_BYTE;
                  crc_cnt_in    = crc_cnt_ff + 2'd1;
               end
            end
            default: begin
               phase_in = PH_IDLE;
               if (req_rx_byte == start_ff) begin
                  count_in   = 8'd0;
                  crc_cnt_in = 2'd0;
                  phase_in   = PH_CMD;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         start_ff   <= fpr_pkg::START_RESET;
         command_ff <= 8'd0;
         length_ff  <= 8'd0;
         count_ff   <= 8'd0;
         crc_cnt_ff <= 2'd0;
      end else begin
         phase_ff   <= phase_in;
         start_ff   <= start_in;
         command_ff <= command_in;
         length_ff  <= length_in;
         count_ff   <= count_in;
         crc_cnt_ff <= crc_cnt_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/core/fpr_queue.sv */
// ---------------------------------------------------------------------------
// Framed packet receiver work queue
// Short first-in first-out queue between the front and back ends.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fpr_queue #(
   parameter int DEPTH = 4
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         push,
   input  wire fpr_pkg::fpr_entry_type       push_entry,
   input  wire logic                         pop,
   output fpr_pkg::fpr_entry_type            head,
   output fpr_pkg::fpr_queue_status_type     status
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL = CNT_W'(DEPTH);

   fpr_pkg::fpr_entry_type slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ff, wr_in;
   logic [PTR_W-1:0] rd_ff, rd_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             do_push;
   logic             do_pop;

   assign status.full  = (cnt_ff == FULL);
   assign status.empty = (cnt_ff == '0);
   assign head         = slot_ff[rd_ff];
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (do_push) begin
         wr_in = (wr_ff == LAST) ? '0 : wr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_in = (rd_ff == LAST) ? '0 : rd_ff + PTR_W'(1);
      end
      case ({do_push, do_pop})
         2'b10:   cnt_in = cnt_ff + CNT_W'(1);
         2'b01:   cnt_in = cnt_ff - CNT_W'(1);
         default: cnt_in = cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (do_push) begin
         slot_ff[wr_ff] <= push_entry;
      end
   end

endmodule

`default_nettype wire

/* rtl/core/fpr_back.sv */
// ---------------------------------------------------------------------------
// Framed packet receiver back end
// Runs the CRC-32, collects the received CRC and drives the result register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fpr_back (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire fpr_pkg::fpr_entry_type   head,
   input  wire fpr_pkg::fpr_queue_status_type q_status,
   output logic                          pop,
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output logic                          rsp_kind,
   output logic [7:0]                    rsp_payload_byte,
   output logic [7:0]                    rsp_byte_index,
   output logic [7:0]                    rsp_frame_command,
   output logic [7:0]                    rsp_frame_length,
   output logic                          rsp_crc_ok
);

   logic [31:0] crc_ff, crc_in;
   logic [31:0] rx_crc_ff, rx_crc_in;
   logic        valid_ff, valid_in;
   logic        kind_ff, kind_in;
   logic [7:0]  byte_ff, byte_in;
   logic [7:0]  index_ff, index_in;
   logic [7:0]  command_ff, command_in;
   logic [7:0]  length_ff, length_in;
   logic        ok_ff, ok_in;
   logic        needs_rsp;
   logic        slot_free;
   logic [31:0] crc_next;

   assign needs_rsp = (head.op == fpr_pkg::OP_PAYLOAD) || (head.op == fpr_pkg::OP_CRC_LAST);
   assign slot_free = !valid_ff || !rsp_stall;
   assign pop       = !q_status.empty && (!needs_rsp || slot_free);
   assign crc_next  = fpr_pkg::crc_feed(
                         (head.op == fpr_pkg::OP_FIRST) ? fpr_pkg::CRC_PRESET : crc_ff,
                         head.data);

   always_comb begin
      crc_in     = crc_ff;
      rx_crc_in  = rx_crc_ff;
      valid_in   = valid_ff && rsp_stall;
      kind_in    = kind_ff;
      byte_in    = byte_ff;
      index_in   = index_ff;
      command_in = command_ff;
      length_in  = length_ff;
      ok_in      = ok_ff;
      if (pop) begin
         unique case (head.op) inside
            fpr_pkg::OP_FIRST,
            fpr_pkg::OP_FEED: begin
               crc_in = crc_next;
            end
            fpr_pkg::OP_PAYLOAD: begin
               crc_in     = crc_next;
               valid_in   = 1'b1;
               kind_in    = 1'b0;
               byte_in    = head.data;
               index_in   = head.index;
               command_in = head.command;
               length_in  = head.length;
               ok_in      = 1'b0;
            end
            fpr_pkg::OP_CRC_BYTE: begin
               rx_crc_in = {rx_crc_ff[23:0], head.data};
            end
            fpr_pkg::OP_CRC_LAST: begin
               rx_crc_in  = {rx_crc_ff[23:0], head.data};
               valid_in   = 1'b1;
               kind_in    = 1'b1;
               byte_in    = 8'd0;
               index_in   = 8'd0;
               command_in = head.command;
               length_in  = head.length;
               ok_in      = ({rx_crc_ff[23:0], head.data} == crc_ff);
            end
            default: begin
               crc_in = crc_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff   <= fpr_pkg::CRC_PRESET;
         valid_ff <= 1'b0;
      end else begin
         crc_ff   <= crc_in;
         valid_ff <= valid_in;
      end
      rx_crc_ff  <= rx_crc_in;
      kind_ff    <= kind_in;
      byte_ff    <= byte_in;
      index_ff   <= index_in;
      command_ff <= command_in;
      length_ff  <= length_in;
      ok_ff      <= ok_in;
   end

   assign rsp_valid         = valid_ff;
   assign rsp_kind          = kind_ff;
   assign rsp_payload_byte  = byte_ff;
   assign rsp_byte_index    = index_ff;
   assign rsp_frame_command = command_ff;
   assign rsp_frame_length  = length_ff;
   assign rsp_crc_ok        = ok_ff;

endmodule

`default_nettype wire

/* test/tb_framed_packet_receiver_crc32_core.sv */
// ---------------------------------------------------------------------------
// Framed packet receiver core testbench
// Drives framed byte streams with good and corrupted CRCs, noise and cut-off
// frames under several start bytes, with random gaps on both channels and one
// long result hold-off. Every result is compared field by field with a frame
// decoder kept inside the testbench.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_framed_packet_receiver_crc32_core;

   localparam logic [31:0] CRC_SEED       = 32'hFFFF_FFFF;
   localparam logic [31:0] CRC32_POLY     = 32'h04C1_1DB7;
   localparam logic [7:0]  START_AT_RESET = 8'hAA;
   localparam int unsigned DRAIN_CYCLES   = 16;
   localparam int unsigned HOLD_CYCLES    = 400;
   localparam int unsigned PHASE_BYTES    = 330;
   localparam int unsigned CYCLE_LIMIT    = 300000;
   localparam int unsigned REPORT_LIMIT   = 10;

   typedef enum logic [2:0] {
      RX_HUNT,
      RX_COMMAND,
      RX_LENGTH,
      RX_PAYLOAD,
      RX_CHECK
   } rx_phase_type;

   typedef struct packed {
      logic       kind;
      logic [7:0] payload_byte;
      logic [7:0] byte_index;
      logic [7:0] frame_command;
      logic [7:0] frame_length;
      logic       crc_ok;
   } frame_result_type;

   logic       clock;
   logic       reset          = 1'b1;
   logic       req_valid      = 1'b0;
   logic [7:0] req_rx_byte    = 8'h00;
   logic       req_stall;
   logic       rsp_valid;
   logic       rsp_stall;
   logic       rsp_kind;
   logic [7:0] rsp_payload_byte;
   logic [7:0] rsp_byte_index;
   logic [7:0] rsp_frame_command;
   logic [7:0] rsp_frame_length;
   logic       rsp_crc_ok;
   logic       csr_valid      = 1'b0;
   logic       csr_ready;
   logic [7:0] csr_start_byte = 8'h00;

   logic       recv_stall     = 1'b0;
   logic       long_hold      = 1'b0;
   bit         quiet_mode     = 1'b0;
   event       start_hold;

   logic [7:0]       pending_bytes[$];
   logic [7:0]       frame_body[$];
   frame_result_type expected_results[$];

   int unsigned send_gap      = 0;
   int unsigned recv_wait     = 0;
   int unsigned bytes_queued  = 0;
   int unsigned failure_count = 0;
   int unsigned cycle_count   = 0;

   rx_phase_type rx_phase     = RX_HUNT;
   logic [7:0]   rx_start     = START_AT_RESET;
   logic [7:0]   rx_command   = 8'h00;
   logic [7:0]   rx_length    = 8'h00;
   logic [7:0]   rx_count     = 8'h00;
   logic [31:0]  rx_crc       = CRC_SEED;
   logic [31:0]  rx_received  = 32'h0;
   logic [1:0]   rx_crc_bytes = 2'd0;

   assign rsp_stall = recv_stall | long_hold;

   framed_packet_receiver_crc32_core u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_rx_byte       (req_rx_byte),
      .req_stall         (req_stall),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_kind          (rsp_kind),
      .rsp_payload_byte  (rsp_payload_byte),
      .rsp_byte_index    (rsp_byte_index),
      .rsp_frame_command (rsp_frame_command),
      .rsp_frame_length  (rsp_frame_length),
      .rsp_crc_ok        (rsp_crc_ok),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_start_byte    (csr_start_byte)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic logic [31:0] crc32_step(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] c;
      logic        feedback;
      c = crc;
      for (int i = 7; i >= 0; i--) begin
         feedback = c[31] ^ b[i];
         c = {c[30:0], 1'b0} ^ (feedback ? CRC32_POLY : 32'h0);
      end
      return c;
   endfunction

   function automatic int unsigned draw_wait(input bit no_idle);
      if (no_idle) begin
         return 0;
      end
      case ($urandom_range(0, 3))
         0, 1: begin
            return 0;
         end
         2: begin
            return $urandom_range(1, 3);
         end
         default: begin
            return $urandom_range(0, 16);
         end
      endcase
   endfunction

   function automatic string describe(input frame_result_type r);
      return $sformatf("kind=%0d byte=%02h index=%0d command=%02h length=%0d crc_ok=%0d",
                       r.kind, r.payload_byte, r.byte_index, r.frame_command,
                       r.frame_length, r.crc_ok);
   endfunction

   task automatic report_failure(input string what);
      failure_count++;
      if (failure_count <= REPORT_LIMIT) begin
         $display("%0t: %s", $realtime, what);
      end
   endtask

   // Decodes one accepted request and records the result it should produce.
   task automatic receive_byte(input logic [7:0] b);
      frame_result_type r;
      r = '0;
      case (rx_phase)
         RX_COMMAND: begin
            rx_command = b;
            rx_crc     = crc32_step(rx_crc, b);
            rx_phase   = RX_LENGTH;
         end
         RX_LENGTH: begin
            rx_length    = b;
            rx_crc       = crc32_step(rx_crc, b);
            rx_count     = 8'h00;
            rx_crc_bytes = 2'd0;
            rx_phase     = (b == 8'h00) ? RX_CHECK : RX_PAYLOAD;
         end
         RX_PAYLOAD: begin
            rx_crc          = crc32_step(rx_crc, b);
            r.payload_byte  = b;
            r.byte_index    = rx_count;
            r.frame_command = rx_command;
            r.frame_length  = rx_length;
            expected_results.push_back(r);
            rx_count = rx_count + 8'd1;
            if (rx_count == rx_length) begin
               rx_phase = RX_CHECK;
            end
         end
         RX_CHECK: begin
            rx_received = {rx_received[23:0], b};
            if (rx_crc_bytes == 2'd3) begin
               rx_crc_bytes    = 2'd0;
               rx_phase        = RX_HUNT;
               r.kind          = 1'b1;
               r.frame_command = rx_command;
               r.frame_length  = rx_length;
               r.crc_ok        = (rx_received == rx_crc);
               expected_results.push_back(r);
            end else begin
               rx_crc_bytes = rx_crc_bytes + 2'd1;
            end
         end
         default: begin
            rx_phase = RX_HUNT;
            if (b == rx_start) begin
               rx_crc       = CRC_SEED;
               rx_received  = 32'h0;
               rx_count     = 8'h00;
               rx_crc_bytes = 2'd0;
               rx_phase     = RX_COMMAND;
            end
         end
      endcase
   endtask

   task automatic queue_byte(input logic [7:0] b);
      pending_bytes.push_back(b);
      bytes_queued++;
   endtask

   task automatic queue_frame(input bit corrupt);
      logic [31:0] crc;
      crc = CRC_SEED;
      foreach (frame_body[i]) begin
         crc = crc32_step(crc, frame_body[i]);
      end
      if (corrupt) begin
         crc = crc ^ (32'h1 << $urandom_range(0, 31));
      end
      queue_byte(rx_start);
      foreach (frame_body[i]) begin
         queue_byte(frame_body[i]);
      end
      for (int k = 3; k >= 0; k--) begin
         queue_byte(crc[8 * k +: 8]);
      end
   endtask

   task automatic queue_noise();
      logic [7:0] b;
      repeat ($urandom_range(1, 4)) begin
         do begin
            b = 8'($urandom_range(0, 255));
         end while (b == rx_start);
         queue_byte(b);
      end
   endtask

   task automatic queue_random_frame();
      int unsigned pick;
      int unsigned len;
      pick = $urandom_range(0, 99);
      if (pick < 85) begin
         len = $urandom_range(0, 12);
      end else if (pick < 97) begin
         len = $urandom_range(13, 64);
      end else begin
         len = $urandom_range(65, 255);
      end
      frame_body.delete();
      frame_body.push_back(8'($urandom_range(0, 255)));
      frame_body.push_back(len[7:0]);
      repeat (len) begin
         frame_body.push_back(8'($urandom_range(0, 255)));
      end
      queue_frame($urandom_range(0, 3) == 0);
   endtask

   task automatic fill_phase(input int unsigned count);
      int unsigned target;
      target = bytes_queued + count;
      while (bytes_queued < target) begin
         case ($urandom_range(0, 99)) inside
            [0:14]: begin
               queue_noise();
            end
            [15:18]: begin
               queue_byte(rx_start);
               repeat ($urandom_range(1, 3)) begin
                  queue_byte(8'($urandom_range(0, 255)));
               end
            end
            default: begin
               queue_random_frame();
            end
         endcase
      end
   endtask

   task automatic wait_idle();
      do begin
         @(negedge clock);
      end while (pending_bytes.size() != 0 || req_valid || expected_results.size() != 0);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_start_byte(input logic [7:0] value);
      @(posedge clock);
      csr_valid      <= 1'b1;
      csr_start_byte <= value;
      do begin
         @(posedge clock);
      end while (!csr_ready);
      csr_valid <= 1'b0;
      rx_start = value;
      @(negedge clock);
   endtask

   // Request driver: one byte per request, gap drawn per request.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_valid && !req_stall) begin
            receive_byte(req_rx_byte);
         end
         if (!req_valid || !req_stall) begin
            if (send_gap == 0 && pending_bytes.size() != 0) begin
               req_valid   <= 1'b1;
               req_rx_byte <= pending_bytes.pop_front();
               send_gap = draw_wait(quiet_mode);
            end else begin
               req_valid <= 1'b0;
               if (send_gap != 0) begin
                  send_gap--;
               end
            end
         end
      end
   end

   // Result monitor and receiver stall.
   always @(posedge clock) begin
      frame_result_type got;
      frame_result_type want;
      if (reset) begin
         recv_stall <= 1'b0;
         recv_wait = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got = {rsp_kind, rsp_payload_byte, rsp_byte_index, rsp_frame_command,
                   rsp_frame_length, rsp_crc_ok};
            if (expected_results.size() == 0) begin
               report_failure({"unexpected result: ", describe(got)});
            end else begin
               want = expected_results.pop_front();
               if (got.kind !== want.kind || got.payload_byte !== want.payload_byte ||
                   got.byte_index !== want.byte_index ||
                   got.frame_command !== want.frame_command ||
                   got.frame_length !== want.frame_length || got.crc_ok !== want.crc_ok) begin
                  report_failure({"mismatch: expected ", describe(want), " got ",
                                  describe(got)});
               end
            end
            recv_wait = draw_wait(quiet_mode);
         end else if (recv_wait != 0) begin
            recv_wait--;
         end
         recv_stall <= (recv_wait != 0);
      end
   end

   // Long hold-off of the result channel while requests keep arriving.
   initial begin
      forever begin
         @(start_hold);
         @(posedge clock);
         long_hold <= 1'b1;
         repeat (HOLD_CYCLES) @(posedge clock);
         long_hold <= 1'b0;
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin
      logic [7:0] start_values[5];
      start_values[0] = 8'h00;
      start_values[1] = 8'hFF;
      start_values[2] = 8'($urandom_range(0, 255));
      start_values[3] = 8'($urandom_range(0, 255));
      start_values[4] = START_AT_RESET;

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Noise, an empty frame, the start byte inside a frame and a bad CRC.
      queue_byte(8'h00);
      queue_byte(8'hFF);
      frame_body = {8'h00, 8'h00};
      queue_frame(1'b0);
      frame_body = {START_AT_RESET, 8'h02, START_AT_RESET, 8'hFF};
      queue_frame(1'b0);
      frame_body = {8'hFF, 8'h01, 8'h55};
      queue_frame(1'b1);
      wait_idle();

      for (int p = 0; p < 5; p++) begin
         write_start_byte(start_values[p]);
         quiet_mode = (p == 1) || (p == 2);
         if (p == 2) begin
            -> start_hold;
         end
         fill_phase(PHASE_BYTES);
         wait_idle();
      end

      if (failure_count == 0 && expected_results.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
